/* hw/rtl/dht_pkg.sv */
// Shared types and constants of the drag hit-test tracker.
// No dependencies; the interfaces and the top level use it.
package dht_pkg;

	localparam int PIX_W   = 11;
	localparam int SCALE_W = 11;
	localparam int HALF_W  = 17;
	localparam int POS_W   = 20;
	localparam int FUNC_W  = 2;
	localparam int BTN_W   = 3;

	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 2;

	localparam int POS_MAX = 524287;
	localparam int POS_MIN = -524288;

	// event kinds
	localparam logic [FUNC_W-1:0] FUNC_PRESS   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_MOVE    = 2'd2;

	localparam logic [BTN_W-1:0] BTN_LEFT = 3'd0;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_X_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF    = 2'd2;

	localparam logic [SCALE_W-1:0] X_SCALE_RESET = 11'd400;
	localparam logic [SCALE_W-1:0] Y_SCALE_RESET = 11'd300;
	localparam logic [HALF_W-1:0]  HALF_RESET    = 17'd6554;

endpackage

/* hw/rtl/dht_evt_if.sv */
// Pointer event channel: valid/ready handshake and the event fields.
// Depends on dht_pkg for field widths.
interface dht_evt_if;
	logic                        valid;
	logic                        ready;
	logic [dht_pkg::FUNC_W-1:0]  func;
	logic [dht_pkg::BTN_W-1:0]   button;
	logic [dht_pkg::PIX_W-1:0]   cursor_x;
	logic [dht_pkg::PIX_W-1:0]   cursor_y;

	modport source (output valid, func, button, cursor_x, cursor_y, input ready);
	modport sink   (input valid, func, button, cursor_x, cursor_y, output ready);
endinterface

/* hw/rtl/dht_res_if.sv */
// Result channel: valid/ready handshake and the tracker state after an event.
// Depends on dht_pkg for field widths.
interface dht_res_if;
	logic                              valid;
	logic                              ready;
	logic                              dragging;
	logic                              hit;
	logic signed [dht_pkg::POS_W-1:0]  object_x;
	logic signed [dht_pkg::POS_W-1:0]  object_y;

	modport source (output valid, dragging, hit, object_x, object_y, input ready);
	modport sink   (input valid, dragging, hit, object_x, object_y, output ready);
endinterface

/* hw/rtl/drag_hit_test_tracker.sv */
// Drag hit-test tracker top level: event sequencer, shared divider, hit test.
// Depends on dht_pkg, dht_evt_if and dht_res_if.
//
// Each pointer event item is taken while the block is idle, then the cursor
// position is normalised by one shared restoring divider, one quotient bit per
// cycle: first x / x_scale_pixels, then y / y_scale_pixels. The normalise state
// subtracts the unit from the x quotient and the y quotient from the unit,
// saturates both to the 20-bit range and forms the square's bounds; the
// evaluate state then compares and commits. An item occupies the block until
// its commit, and the next item is taken only once the block is back in idle.
// The result sits in an output register, so the following item is accepted
// while it waits; the commit holds only while that register is full and not
// being taken. Every event yields exactly one result. For the axis-aligned
// square the even-odd ray test reduces to a half-open box check (left and
// bottom edges in, right and top edges out), and a zero half size never hits.
// A scale register holding zero divides as if it held one.
module drag_hit_test_tracker #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dht_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dht_pkg::CFG_W-1:0]     cfg_data,
	dht_evt_if.sink                       evt,
	dht_res_if.source                     res
);
	import dht_pkg::*;

	localparam int Q_W  = PIX_W + FRAC_BITS;      // dividend and quotient width
	localparam int CNT_W = $clog2(Q_W);
	localparam int D_W  = Q_W + 2;                // signed working width
	localparam int B_W  = POS_W + 2;              // bounds width

	localparam logic signed [D_W-1:0] ONE_FX  = D_W'(64'd1 << FRAC_BITS);
	localparam logic signed [D_W-1:0] SAT_MAX = D_W'(POS_MAX);
	localparam logic signed [D_W-1:0] SAT_MIN = D_W'(POS_MIN);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIVX = 5'b00010,
		ST_DIVY = 5'b00100,
		ST_NORM = 5'b01000,
		ST_EVAL = 5'b10000
	} state_t;

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [D_W-1:0] v);
		logic signed [POS_W-1:0] r;
		if (v > SAT_MAX) begin
			r = POS_W'(SAT_MAX);
		end else if (v < SAT_MIN) begin
			r = POS_W'(SAT_MIN);
		end else begin
			r = v[POS_W-1:0];
		end
		return r;
	endfunction

	state_t state_q;

	// configuration
	logic [SCALE_W-1:0] x_scale_q, y_scale_q;
	logic [HALF_W-1:0]  half_q;

	// tracker state
	logic signed [POS_W-1:0] obj_x_q, obj_y_q;
	logic                    drag_q;

	// captured event
	logic [FUNC_W-1:0] func_q;
	logic [BTN_W-1:0]  btn_q;
	logic [PIX_W-1:0]  cur_y_q;

	// divider
	logic [Q_W-1:0]     num_q;
	logic [SCALE_W-1:0] rem_q;
	logic [SCALE_W-1:0] div_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [Q_W-1:0]     qx_q;

	// normalised point and square bounds
	logic signed [POS_W-1:0] nx_q, ny_q;
	logic signed [B_W-1:0]   lo_x_q, hi_x_q, lo_y_q, hi_y_q;
	logic                    half_nz_q;

	// result register
	logic                    res_valid_q;
	logic                    res_drag_q, res_hit_q;
	logic signed [POS_W-1:0] res_x_q, res_y_q;

	logic [SCALE_W:0]   shifted, trial;
	logic               ge;
	logic [SCALE_W-1:0] rem_nxt;
	logic [Q_W-1:0]     num_nxt;
	logic [SCALE_W-1:0] xs_eff, ys_eff;
	logic               div_last;
	logic               out_free;
	logic               commit;
	logic               hit;
	logic               left;
	logic signed [B_W-1:0] ox_e, oy_e, h_e, px_e, py_e;

	// restoring divide step
	always_comb begin
		shifted = {rem_q, num_q[Q_W-1]};
		trial   = shifted - {1'b0, div_q};
		ge      = shifted >= {1'b0, div_q};
		rem_nxt = ge ? trial[SCALE_W-1:0] : shifted[SCALE_W-1:0];
		num_nxt = {num_q[Q_W-2:0], ge};
	end

	assign xs_eff   = (x_scale_q == '0) ? SCALE_W'(1) : x_scale_q;
	assign ys_eff   = (y_scale_q == '0) ? SCALE_W'(1) : y_scale_q;
	assign div_last = (cnt_q == '0);

	assign ox_e = B_W'(obj_x_q);
	assign oy_e = B_W'(obj_y_q);
	assign h_e  = $signed({{(B_W-HALF_W){1'b0}}, half_q});
	assign px_e = B_W'(nx_q);
	assign py_e = B_W'(ny_q);

	// half-open box: what the even-odd ray test gives for this square
	assign hit = half_nz_q && (px_e >= lo_x_q) && (px_e < hi_x_q)
	             && (py_e >= lo_y_q) && (py_e < hi_y_q);

	assign left     = (btn_q == BTN_LEFT);
	assign out_free = !res_valid_q || res.ready;
	assign commit   = (state_q == ST_EVAL) && out_free;

	assign evt.ready    = (state_q == ST_IDLE);
	assign res.valid    = res_valid_q;
	assign res.dragging = res_drag_q;
	assign res.hit      = res_hit_q;
	assign res.object_x = res_x_q;
	assign res.object_y = res_y_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_scale_q <= X_SCALE_RESET;
			y_scale_q <= Y_SCALE_RESET;
			half_q    <= HALF_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_X_SCALE: x_scale_q <= cfg_data[SCALE_W-1:0];
				REG_Y_SCALE: y_scale_q <= cfg_data[SCALE_W-1:0];
				REG_HALF:    half_q    <= cfg_data[HALF_W-1:0];
				default:     ;
			endcase
		end
	end

	// sequencer and tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			drag_q      <= 1'b0;
			obj_x_q     <= '0;
			obj_y_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (evt.valid) begin
						state_q <= ST_DIVX;
					end
				end
				ST_DIVX: begin
					if (div_last) begin
						state_q <= ST_DIVY;
					end
				end
				ST_DIVY: begin
					if (div_last) begin
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						priority if (func_q == FUNC_PRESS && left) begin
							if (hit) begin
								drag_q <= 1'b1;
							end
						end else if (func_q == FUNC_RELEASE && left) begin
							drag_q <= 1'b0;
						end else if (func_q == FUNC_MOVE && drag_q) begin
							obj_x_q <= nx_q;
							obj_y_q <= ny_q;
						end else begin
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: capture, divider iterations, normalisation, result
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				func_q  <= evt.func;
				btn_q   <= evt.button;
				cur_y_q <= evt.cursor_y;
				num_q   <= {evt.cursor_x, {FRAC_BITS{1'b0}}};
				rem_q   <= '0;
				div_q   <= xs_eff;
				cnt_q   <= CNT_W'(Q_W - 1);
			end
			ST_DIVX: begin
				if (div_last) begin
					// x quotient done; reload the unit for y
					qx_q  <= num_nxt;
					num_q <= {cur_y_q, {FRAC_BITS{1'b0}}};
					rem_q <= '0;
					div_q <= ys_eff;
					cnt_q <= CNT_W'(Q_W - 1);
				end else begin
					num_q <= num_nxt;
					rem_q <= rem_nxt;
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
			ST_DIVY: begin
				num_q <= num_nxt;
				rem_q <= rem_nxt;
				cnt_q <= cnt_q - CNT_W'(1);
			end
			ST_NORM: begin
				nx_q      <= sat_pos($signed({2'b00, qx_q}) - ONE_FX);
				ny_q      <= sat_pos(ONE_FX - $signed({2'b00, num_q}));
				lo_x_q    <= ox_e - h_e;
				hi_x_q    <= ox_e + h_e;
				lo_y_q    <= oy_e - h_e;
				hi_y_q    <= oy_e + h_e;
				half_nz_q <= (half_q != '0);
			end
			ST_EVAL: begin
				if (out_free) begin
					res_hit_q <= (func_q == FUNC_PRESS) && left && hit;
					priority if (func_q == FUNC_PRESS && left) begin
						res_drag_q <= drag_q | hit;
						res_x_q    <= obj_x_q;
						res_y_q    <= obj_y_q;
					end else if (func_q == FUNC_RELEASE && left) begin
						res_drag_q <= 1'b0;
						res_x_q    <= obj_x_q;
						res_y_q    <= obj_y_q;
					end else if (func_q == FUNC_MOVE && drag_q) begin
						res_drag_q <= 1'b1;
						res_x_q    <= nx_q;
						res_y_q    <= ny_q;
					end else begin
						res_drag_q <= drag_q;
						res_x_q    <= obj_x_q;
						res_y_q    <= obj_y_q;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

/* dv/tb_drag_hit_test_tracker.sv */
// Self-checking testbench for the drag hit-test tracker: pointer events in, state items out.
// Needs dht_pkg, dht_evt_if, dht_res_if and drag_hit_test_tracker from the RTL.
module tb_drag_hit_test_tracker;
	timeunit 1ns;
	timeprecision 1ps;

	import dht_pkg::*;

	localparam int     FRAC  = 16;
	localparam longint UNIT  = longint'(1) << FRAC;
	localparam int     PIX_MAX = (1 << PIX_W) - 1;

	// event kind with no meaning to the block
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	// one pointer event as it goes onto the event channel
	typedef struct {
		logic [FUNC_W-1:0] func;
		logic [BTN_W-1:0]  button;
		logic [PIX_W-1:0]  cx;
		logic [PIX_W-1:0]  cy;
	} ptr_event_t;

	// tracker state after an event, as seen on the result channel
	typedef struct {
		logic                    dragging;
		logic                    hit;
		logic signed [POS_W-1:0] obj_x;
		logic signed [POS_W-1:0] obj_y;
	} track_result_t;

	typedef struct {
		logic signed [POS_W-1:0] obj_x;
		logic signed [POS_W-1:0] obj_y;
		logic                    drag;
	} track_state_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	dht_evt_if evt();
	dht_res_if res();

	drag_hit_test_tracker #(.FRAC_BITS(FRAC)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.evt       (evt),
		.res       (res)
	);

	// Register copies as last written; only ever changed while the block is idle.
	logic [SCALE_W-1:0] cfg_x_scale = X_SCALE_RESET;
	logic [SCALE_W-1:0] cfg_y_scale = Y_SCALE_RESET;
	logic [HALF_W-1:0]  cfg_half    = HALF_RESET;

	// Two copies of the tracker state: one follows accepted items (checking),
	// the other runs ahead on queued items so the stimulus can aim at the object.
	track_state_t  tracked_state = '{obj_x: '0, obj_y: '0, drag: 1'b0};
	track_state_t  aim_state     = '{obj_x: '0, obj_y: '0, drag: 1'b0};

	ptr_event_t    event_queue[$];
	track_result_t track_expected[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatch_count = 0;
	int counted_items = 0;

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- prediction

	// (pixel << FRAC) / scale, floor; a zero scale divides as one
	function automatic longint scaled_pixel(input logic [PIX_W-1:0] pix,
			input logic [SCALE_W-1:0] scale);
		longint d;
		d = (scale == '0) ? 1 : longint'(scale);
		return (longint'(pix) << FRAC) / d;
	endfunction

	function automatic longint sat_pos(input longint v);
		if (v > POS_MAX)
			return POS_MAX;
		if (v < POS_MIN)
			return POS_MIN;
		return v;
	endfunction

	function automatic longint norm_x(input logic [PIX_W-1:0] pix);
		return sat_pos(scaled_pixel(pix, cfg_x_scale) - UNIT);
	endfunction

	function automatic longint norm_y(input logic [PIX_W-1:0] pix);
		return sat_pos(UNIT - scaled_pixel(pix, cfg_y_scale));
	endfunction

	// Even-odd ray cast against the four corners of the square, corners at full
	// precision. An edge counts when exactly one end lies strictly above the
	// point and the point lies strictly left of the crossing (quotient toward
	// zero, which SV signed division gives as it is).
	function automatic bit in_square(input longint px, input longint py,
			input longint ox, input longint oy, input longint h);
		longint cxs[4];
		longint cys[4];
		longint xc;
		bit     odd;
		int     j;
		cxs[0] = ox - h; cys[0] = oy - h;
		cxs[1] = ox + h; cys[1] = oy - h;
		cxs[2] = ox + h; cys[2] = oy + h;
		cxs[3] = ox - h; cys[3] = oy + h;
		odd = 1'b0;
		for (int i = 0; i < 4; i++) begin
			j = (i + 3) % 4;
			if ((cys[i] > py) != (cys[j] > py)) begin
				xc = (cxs[j] - cxs[i]) * (py - cys[i]) / (cys[j] - cys[i]) + cxs[i];
				if (px < xc)
					odd = ~odd;
			end
		end
		return odd;
	endfunction

	// Applies one event to a state copy and returns the item the block should send.
	function automatic track_result_t apply_event(inout track_state_t st,
			input ptr_event_t ev);
		track_result_t r;
		longint        nx;
		longint        ny;
		nx = norm_x(ev.cx);
		ny = norm_y(ev.cy);
		r.hit = 1'b0;
		if (ev.func == FUNC_PRESS && ev.button == BTN_LEFT) begin
			r.hit = in_square(nx, ny, longint'(st.obj_x), longint'(st.obj_y),
				longint'(cfg_half));
			if (r.hit)
				st.drag = 1'b1;
		end else if (ev.func == FUNC_RELEASE && ev.button == BTN_LEFT) begin
			st.drag = 1'b0;
		end else if (ev.func == FUNC_MOVE && st.drag) begin
			st.obj_x = POS_W'(nx);
			st.obj_y = POS_W'(ny);
		end
		r.dragging = st.drag;
		r.obj_x    = st.obj_x;
		r.obj_y    = st.obj_y;
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic logic [PIX_W-1:0] clamp_pix(input longint p);
		if (p < 0)
			return '0;
		if (p > PIX_MAX)
			return PIX_W'(PIX_MAX);
		return p[PIX_W-1:0];
	endfunction

	// Smallest pixel whose normalised value reaches the target (ceil of the inverse map).
	// flip selects the y map, where the axis runs the other way.
	function automatic logic [PIX_W-1:0] pixel_for(input longint target,
			input logic [SCALE_W-1:0] scale, input bit flip);
		longint num;
		longint eff;
		eff = (scale == '0) ? 1 : longint'(scale);
		num = flip ? (UNIT - target) : (target + UNIT);
		return clamp_pix((num * eff + UNIT - 1) >>> FRAC);
	endfunction

	// Queues an item and runs it through the look-ahead state. Only moves and
	// left-button presses and releases count towards the phase's total.
	task automatic queue_event(input logic [FUNC_W-1:0] f, input logic [BTN_W-1:0] b,
			input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
		ptr_event_t ev;
		ev = '{func: f, button: b, cx: x, cy: y};
		event_queue = {event_queue, ev};
		void'(apply_event(aim_state, ev));
		if (f == FUNC_MOVE || ((f == FUNC_PRESS || f == FUNC_RELEASE) && b == BTN_LEFT))
			counted_items++;
	endtask

	// Picks a pixel that lands on the object where one exists near the inverse map;
	// falls back to the plain inverse when no neighbour hits (tiny or empty square).
	task automatic aim_at_object(output logic [PIX_W-1:0] ax, output logic [PIX_W-1:0] ay);
		logic [PIX_W-1:0] bx;
		logic [PIX_W-1:0] by;
		logic [PIX_W-1:0] tx;
		logic [PIX_W-1:0] ty;
		bx = pixel_for(longint'(aim_state.obj_x), cfg_x_scale, 1'b0);
		by = pixel_for(longint'(aim_state.obj_y), cfg_y_scale, 1'b1);
		ax = bx;
		ay = by;
		for (int dy = 1; dy >= -1; dy--) begin
			for (int dx = 1; dx >= -1; dx--) begin
				tx = clamp_pix(longint'(bx) + dx);
				ty = clamp_pix(longint'(by) + dy);
				if (in_square(norm_x(tx), norm_y(ty), longint'(aim_state.obj_x),
						longint'(aim_state.obj_y), longint'(cfg_half))) begin
					ax = tx;
					ay = ty;
				end
			end
		end
	endtask

	// Mostly well-formed drags (press on the object, a few moves, left release),
	// some with the press pushed out to the square's border, some left broken,
	// and the rest random noise over every field.
	task automatic queue_random(input int n);
		logic [PIX_W-1:0] ax;
		logic [PIX_W-1:0] ay;
		longint           hpx;
		longint           hpy;
		int               moves;
		int               pick;
		counted_items = 0;
		while (counted_items < n) begin
			if ($urandom_range(99) < 65) begin
				if (!aim_state.drag) begin
					aim_at_object(ax, ay);
					if ($urandom_range(99) < 30) begin
						// probe around the border in pixel units
						hpx = (longint'(cfg_half) * longint'(cfg_x_scale)) >>> FRAC;
						hpy = (longint'(cfg_half) * longint'(cfg_y_scale)) >>> FRAC;
						ax = clamp_pix(longint'(ax) + $urandom_range(0, 2 * hpx + 2) - (hpx + 1));
						ay = clamp_pix(longint'(ay) + $urandom_range(0, 2 * hpy + 2) - (hpy + 1));
					end
					queue_event(FUNC_PRESS, BTN_LEFT, ax, ay);
				end
				moves = $urandom_range(1, 5);
				repeat (moves)
					queue_event(FUNC_MOVE, BTN_W'($urandom_range(0, 7)),
						PIX_W'($urandom_range(0, PIX_MAX)), PIX_W'($urandom_range(0, PIX_MAX)));
				pick = $urandom_range(99);
				if (pick < 80)
					queue_event(FUNC_RELEASE, BTN_LEFT, PIX_W'($urandom_range(0, PIX_MAX)),
						PIX_W'($urandom_range(0, PIX_MAX)));
				else if (pick < 90)
					queue_event(FUNC_RELEASE, BTN_W'($urandom_range(1, 7)),
						PIX_W'($urandom_range(0, PIX_MAX)), PIX_W'($urandom_range(0, PIX_MAX)));
				// otherwise the drag is left hanging into whatever follows
			end else begin
				queue_event(FUNC_W'($urandom_range(0, 3)),
					($urandom_range(1) != 0) ? BTN_LEFT : BTN_W'($urandom_range(0, 7)),
					PIX_W'($urandom_range(0, PIX_MAX)), PIX_W'($urandom_range(0, PIX_MAX)));
			end
		end
	endtask

	// Directed opening, reset scales (400, 300) and half size 6554 (about 0.1).
	task automatic queue_directed();
		queue_event(FUNC_PRESS,   BTN_LEFT, 400, 300);    // dead centre: hit, drag starts
		queue_event(FUNC_PRESS,   BTN_LEFT, 400, 300);    // left press while dragging
		queue_event(FUNC_MOVE,    BTN_LEFT, 600, 150);    // object to (0.5, 0.5)
		queue_event(FUNC_MOVE,    3'd7,     0, 0);        // top-left extreme
		queue_event(FUNC_MOVE,    BTN_LEFT, 2047, 2047);  // bottom-right extreme
		queue_event(FUNC_RELEASE, 3'd7,     2047, 2047);  // other button: ignored
		queue_event(FUNC_PRESS,   3'd4,     2047, 2047);  // other button: ignored
		queue_event(FUNC_UNUSED,  BTN_LEFT, 1365, 682);   // unused kind
		queue_event(FUNC_RELEASE, BTN_LEFT, 0, 0);        // drag ends
		queue_event(FUNC_MOVE,    BTN_LEFT, 400, 300);    // move without drag
		queue_event(FUNC_PRESS,   BTN_LEFT, 0, 2047);     // clear miss
		queue_event(FUNC_PRESS,   BTN_LEFT, 2047, 0);     // clear miss, other corner
		queue_event(FUNC_PRESS,   BTN_LEFT, 2047, 2047);  // hit on the moved object
		queue_event(FUNC_MOVE,    BTN_LEFT, 400, 300);    // back to the origin
		queue_event(FUNC_RELEASE, BTN_LEFT, 400, 300);
		queue_event(FUNC_PRESS,   BTN_LEFT, 360, 300);    // exactly on the left border
		queue_event(FUNC_RELEASE, BTN_LEFT, 360, 300);
		queue_event(FUNC_PRESS,   BTN_LEFT, 359, 300);    // one pixel outside it
		queue_event(FUNC_PRESS,   BTN_LEFT, 440, 300);    // just inside the right border
		queue_event(FUNC_RELEASE, BTN_LEFT, 440, 300);
		queue_event(FUNC_PRESS,   BTN_LEFT, 400, 330);    // near the bottom border
		queue_event(FUNC_RELEASE, BTN_LEFT, 400, 330);
		queue_event(FUNC_PRESS,   BTN_LEFT, 400, 270);    // near the top border
		queue_event(FUNC_RELEASE, BTN_LEFT, 400, 270);
	endtask

	// ---------------------------------------------------------------- phase control

	// Returns at a rising edge once nothing is queued, presented or outstanding.
	task automatic wait_idle();
		@(posedge clk);
		while (event_queue.size() != 0 || evt.valid || track_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_W-1:0];
		case (idx)
			REG_X_SCALE: cfg_x_scale = val[SCALE_W-1:0];
			REG_Y_SCALE: cfg_y_scale = val[SCALE_W-1:0];
			REG_HALF:    cfg_half    = val[HALF_W-1:0];
			default:     ;
		endcase
		@(posedge clk);
	endtask

	// Drains the block, rewrites all three registers and resyncs the look-ahead state.
	task automatic set_phase(input int xs, input int ys, input int hs,
			input int s_idle, input int r_idle);
		wait_idle();
		write_reg(REG_X_SCALE, xs);
		write_reg(REG_Y_SCALE, ys);
		write_reg(REG_HALF, hs);
		cfg_we <= 1'b0;
		aim_state     = tracked_state;
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
	endtask

	// ---------------------------------------------------------------- driver

	// A new item goes out only when the channel is free or the current item is
	// being taken at this edge, so valid is written at most once per edge.
	always @(posedge clk) begin : event_driver
		ptr_event_t ev;
		if (!arst_n) begin
			evt.valid <= 1'b0;
		end else if (!evt.valid || evt.ready) begin
			if (event_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				ev = event_queue.pop_front();
				evt.valid    <= 1'b1;
				evt.func     <= ev.func;
				evt.button   <= ev.button;
				evt.cursor_x <= ev.cx;
				evt.cursor_y <= ev.cy;
			end else begin
				evt.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk)
		res.ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);

	// ---------------------------------------------------------------- monitor

	// Checks first, then predicts, so an unexpected result can never be matched
	// against an item taken at the same edge.
	always @(posedge clk) begin : result_check
		track_result_t want;
		track_result_t pred;
		ptr_event_t    seen;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				if (track_expected.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result item: drag=%0d hit=%0d x=%0d y=%0d",
							res.dragging, res.hit, res.object_x, res.object_y);
				end else begin
					want = track_expected.pop_front();
					if (res.dragging !== want.dragging || res.hit !== want.hit ||
							res.object_x !== want.obj_x || res.object_y !== want.obj_y) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$write("result mismatch: expected drag=%0d hit=%0d x=%0d y=%0d,",
								want.dragging, want.hit, want.obj_x, want.obj_y);
							$display(" got drag=%0d hit=%0d x=%0d y=%0d",
								res.dragging, res.hit, res.object_x, res.object_y);
						end
					end
				end
			end
			if (evt.valid && evt.ready) begin
				seen = '{func: evt.func, button: evt.button, cx: evt.cursor_x, cy: evt.cursor_y};
				pred = apply_event(tracked_state, seen);
				track_expected = {track_expected, pred};
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		evt.valid    = 1'b0;
		evt.func     = FUNC_PRESS;
		evt.button   = BTN_LEFT;
		evt.cursor_x = '0;
		evt.cursor_y = '0;
		res.ready    = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// sender idles lightly, receiver stalls hard
		set_phase(int'(X_SCALE_RESET), int'(Y_SCALE_RESET), int'(HALF_RESET), 17, 79);
		queue_directed();
		queue_random(90);
		set_phase(1, 1, 65536, 17, 79);          // smallest scales: saturation, half size of one unit
		queue_random(40);
		set_phase(2047, 2047, 1, 17, 79);        // largest scales, tiny square
		queue_random(50);

		// the other way round
		set_phase(0, 0, 0, 79, 17);              // zero scales, empty square
		queue_random(25);
		set_phase(2047, 1, 131071, 79, 17);      // full 17-bit half size
		queue_random(30);
		set_phase($urandom_range(1, 2047), $urandom_range(1, 2047),
			$urandom_range(1, 65536), 79, 17);
		queue_random(100);

		// back to back
		set_phase(800, 600, 13107, 0, 0);
		queue_random(165);

		wait_idle();
		repeat (120) @(posedge clk);
		if (mismatch_count == 0 && track_expected.size() == 0) begin
			$display("drag_hit_test_tracker verification clean");
		end else begin
			$display("drag_hit_test_tracker verification failed");
		end
		$finish;
	end

	// Timeout that reports failure and ends the run if the sequence has not finished first.
	initial begin
		#5_000_000;
		$display("drag_hit_test_tracker verification failed");
		$finish;
	end

endmodule

/* drag_hit_test_tracker.f */
hw/rtl/dht_pkg.sv
hw/rtl/dht_evt_if.sv
hw/rtl/dht_res_if.sv
hw/rtl/drag_hit_test_tracker.sv
dv/tb_drag_hit_test_tracker.sv
